// ===== hw/rtl/positional_list_engine_core_defines.svh =====
// Assertion macros shared by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a property holds on every clock edge outside reset.
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never occurs outside reset.
`define PLE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== hw/rtl/ple_pkg.sv =====
// Request and status codes of the positional list engine.
`default_nettype none

package ple_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_WRITE  = 3'd2,
    REQ_READ   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  localparam int ReqW   = 3;
  localparam int PosInW = 5;
  localparam int StW    = 2;
  localparam int CountW = 5;

endpackage

`default_nettype wire

// ===== hw/rtl/positional_list_engine_core.sv =====
// Insert shifts the entries from the end down to the position, then writes the value; remove shifts
// the entries above the position down; one request is in flight at a time.
// Each moved entry costs one RAM read and one RAM write through the single read/write port
// pair, stepped by one shared index adder and comparator.
// A new request is taken while the previous result still waits on the master side.
// Reset clears the entry count and all control state; RAM contents are left as they are.
`default_nettype none

`include "positional_list_engine_core_defines.svh"

module positional_list_engine_core #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int InW  = ((ple_pkg::ReqW + ple_pkg::PosInW + WIDTH + 7) / 8) * 8,
  localparam int OutW = ((WIDTH + ple_pkg::StW + ple_pkg::CountW + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // fields from bit 0: req_type[2:0], position[4:0], value[WIDTH-1:0], zero fill
  input  wire logic [InW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i,
  // fields from bit 0: read_value[WIDTH-1:0], status[1:0], entry_count[4:0], zero fill
  output logic      [OutW-1:0] m_axis_tdata_o
);

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int PosW  = (CntW > ple_pkg::PosInW) ? CntW : ple_pkg::PosInW;
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PosW-1:0] DepthP = PosW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_WRITE,
    S_RD_ISSUE,
    S_RD_CAP
  } state_e;

  // Result waiting to move into the output register
  typedef enum logic {
    R_EMPTY,
    R_PEND
  } res_e;

  state_e                state_q, state_d;
  res_e                  res_q, res_d;
  ple_pkg::req_e         in_req;
  logic [PosW-1:0]       in_pos;
  logic [WIDTH-1:0]      in_val;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [WIDTH-1:0]      val_q, val_d;
  logic [PosW-1:0]       idx_q, idx_d;
  logic [PosW-1:0]       count_q, count_d;
  logic [WIDTH-1:0]      res_rd_q, res_rd_d;
  ple_pkg::status_e      res_st_q, res_st_d;
  logic                  m_valid_q, m_valid_d;
  logic [OutW-1:0]       m_data_q, m_data_d;
  logic                  accept;
  logic                  load;
  logic                  step_down;
  logic [PosW-1:0]       idx_step;
  logic                  cmp_hit;
  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [WIDTH-1:0]      ram_wdata;
  logic [AddrW-1:0]      ram_raddr;
  logic [WIDTH-1:0]      ram_rdata;

  // Unpack the request
  assign in_req = ple_pkg::req_e'(s_axis_tdata_i[ple_pkg::ReqW-1:0]);
  assign in_pos = PosW'(s_axis_tdata_i[ple_pkg::ReqW +: ple_pkg::PosInW]);
  assign in_val = s_axis_tdata_i[ple_pkg::ReqW + ple_pkg::PosInW +: WIDTH];

  assign s_axis_tready_o = (state_q == S_IDLE) && (res_q == R_EMPTY);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load            = (res_q == R_PEND) && (!m_valid_q || m_axis_tready_i);

  // Shared index step and compare: inserts walk down, removes walk up
  assign step_down = (state_q == S_INS_RD) || (state_q == S_INS_WR);
  assign idx_step  = step_down ? (idx_q - PosW'(1)) : (idx_q + PosW'(1));
  assign cmp_hit   = step_down ? (idx_q > pos_q) : (idx_step < count_q);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    pos_d     = pos_q;
    val_d     = val_q;
    idx_d     = idx_q;
    count_d   = count_q;
    res_rd_d  = res_rd_q;
    res_st_d  = res_st_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AddrW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_step[AddrW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d    = in_pos;
          val_d    = in_val;
          res_rd_d = '0;
          res_st_d = ple_pkg::ST_DONE;
          case (in_req)
            ple_pkg::REQ_INSERT: begin
              if (in_pos > count_q) begin
                res_st_d = ple_pkg::ST_BADPOS;
                res_d    = R_PEND;
              end else if (count_q == DepthP) begin
                res_st_d = ple_pkg::ST_FULL;
                res_d    = R_PEND;
              end else begin
                idx_d   = count_q;
                state_d = S_INS_RD;
              end
            end
            ple_pkg::REQ_REMOVE: begin
              if (in_pos >= count_q) begin
                res_st_d = ple_pkg::ST_BADPOS;
                res_d    = R_PEND;
              end else begin
                idx_d   = in_pos;
                state_d = S_REM_RD;
              end
            end
            ple_pkg::REQ_WRITE: begin
              if (in_pos >= count_q) begin
                res_st_d = ple_pkg::ST_BADPOS;
                res_d    = R_PEND;
              end else begin
                state_d = S_WRITE;
              end
            end
            ple_pkg::REQ_READ: begin
              if (in_pos >= count_q) begin
                res_st_d = ple_pkg::ST_BADPOS;
                res_d    = R_PEND;
              end else begin
                state_d = S_RD_ISSUE;
              end
            end
            ple_pkg::REQ_CLEAR: begin
              count_d = '0;
              res_d   = R_PEND;
            end
            default: begin
              res_d = R_PEND;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (cmp_hit) begin
          state_d = S_INS_WR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[AddrW-1:0];
          ram_wdata = val_q;
          count_d   = count_q + PosW'(1);
          res_d     = R_PEND;
          state_d   = S_IDLE;
        end
      end
      S_INS_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_step;
        state_d = S_INS_RD;
      end
      S_REM_RD: begin
        if (cmp_hit) begin
          state_d = S_REM_WR;
        end else begin
          count_d = count_q - PosW'(1);
          res_d   = R_PEND;
          state_d = S_IDLE;
        end
      end
      S_REM_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_step;
        state_d = S_REM_RD;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AddrW-1:0];
        ram_wdata = val_q;
        res_d     = R_PEND;
        state_d   = S_IDLE;
      end
      S_RD_ISSUE: begin
        ram_raddr = pos_q[AddrW-1:0];
        state_d   = S_RD_CAP;
      end
      S_RD_CAP: begin
        res_rd_d = ram_rdata;
        res_d    = R_PEND;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      res_d = R_EMPTY;
    end
  end

  // Output register: hold until taken, reload when a result is ready
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    if (load) begin
      m_valid_d = 1'b1;
      m_data_d  = '0;
      m_data_d[WIDTH-1:0] = res_rd_q;
      m_data_d[WIDTH +: ple_pkg::StW] = res_st_q;
      m_data_d[WIDTH + ple_pkg::StW +: ple_pkg::CountW] = count_q[ple_pkg::CountW-1:0];
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_q     <= R_EMPTY;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      pos_q     <= '0;
      val_q     <= '0;
      idx_q     <= '0;
      res_rd_q  <= '0;
      res_st_q  <= ple_pkg::ST_DONE;
      m_data_q  <= '0;
    end else begin
      state_q   <= state_d;
      res_q     <= res_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      pos_q     <= pos_d;
      val_q     <= val_d;
      idx_q     <= idx_d;
      res_rd_q  <= res_rd_d;
      res_st_q  <= res_st_d;
      m_data_q  <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  ple_ram #(
    .Width (WIDTH),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `PLE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= DepthP, "entry count above depth")
  `PLE_ASSERT(a_ins_shift_range, clk_i, rst_ni,
              (state_q == S_INS_WR) |-> (idx_q < DepthP && idx_q > pos_q),
              "insert shift index out of range")
  `PLE_ASSERT(a_full_status, clk_i, rst_ni,
              (load && res_st_q == ple_pkg::ST_FULL) |-> (count_q == DepthP),
              "full status on a list that is not full")
  `PLE_ASSERT_NEVER(a_no_idle_write, clk_i, rst_ni, (state_q == S_IDLE) && ram_we,
                    "store written while idle")

endmodule

`default_nettype wire

// ===== hw/rtl/ple_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ple_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
